// ===== rtl/sorted_key_table_unit_defines.svh =====
// Assertion macros shared by the sorted key table checker.
`ifndef SORTED_KEY_TABLE_UNIT_DEFINES_SVH
`define SORTED_KEY_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SKT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted key table: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted key table: next-cycle check failed");

`endif

// ===== rtl/skt_pkg.sv =====
// Types and constants shared by the sorted key table modules.
`timescale 1ns / 1ps

package skt_pkg;

   // Payload field widths
   localparam int KEY_W      = 32;
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int ENTRY_W    = 7;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   // Operation codes; a set high bit means clear
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_FULL      = 3'd1,
      ST_DELETED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_CLEARED   = 3'd4
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert_en;
      logic remove_en;
   } cell_ctrl_type;

endpackage

// ===== rtl/skt_cell.sv =====
// One slot of the ordered key row: compare against the probe key and shift.
`timescale 1ns / 1ps

module skt_cell #(
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic                              clock,
   input  logic [CNT_W-1:0]                  count,
   input  logic signed [skt_pkg::KEY_W-1:0]  probe_key,
   input  skt_pkg::cell_ctrl_type            ctrl,
   input  logic signed [skt_pkg::KEY_W-1:0]  left_key,
   input  logic                              left_gt,
   input  logic signed [skt_pkg::KEY_W-1:0]  right_key,
   output logic signed [skt_pkg::KEY_W-1:0]  key_q,
   output logic                              gt,
   output logic                              hit
);
   import skt_pkg::*;

   logic signed [KEY_W-1:0] key_ff;
   logic signed [KEY_W-1:0] key_in;
   logic                    occupied;
   logic                    lt;

   // Slot holds a live key when it sits below the fill count
   assign occupied = (CNT_W'(INDEX) < count);

   // Empty slots count as greater than any key
   assign gt  = !occupied || (key_ff > probe_key);
   assign lt  = occupied && (key_ff < probe_key);
   assign hit = occupied && (key_ff == probe_key);

   // Insert: slots above the key take the left neighbor, the boundary slot takes the key.
   // Delete: slots at or above the match take the right neighbor.
   always_comb begin
      priority if (ctrl.insert_en && gt) begin
         key_in = left_gt ? left_key : probe_key;
      end else if (ctrl.remove_en && !lt) begin
         key_in = right_key;
      end else begin
         key_in = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_q = key_ff;

endmodule

// ===== rtl/sorted_key_table_unit.sv =====
// Sorted key table: a row of compare-and-shift cells holding signed keys in ascending order.
// Each request beat (insert, delete one match, or clear) yields one response beat with a
// status and the entry count after the operation. An item passes through two states: IDLE
// captures the beat, then EXEC, in which every cell compares its key with the probe key and shifts toward
// its neighbor; EXEC also ORs the match flags of the whole row for delete.
// The next request is taken while a response still waits in the output register.
// Equal keys are inserted after existing ones; an insert into a full table is rejected.
`timescale 1ns / 1ps

module sorted_key_table_unit #(
   parameter int CAPACITY = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [skt_pkg::REQ_DATA_W-1:0]     req_tdata,   // mode[1:0], key[33:2], zero pad
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [skt_pkg::RSP_DATA_W-1:0]     rsp_tdata    // status[2:0], entry_count[9:3], pad
);
   import skt_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   fsm_type                 state_ff;
   fsm_type                 state_in;
   logic [MODE_W-1:0]       mode_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   status_type              rsp_status_ff;
   status_type              rsp_status_in;
   logic [ENTRY_W-1:0]      rsp_count_ff;
   logic [ENTRY_W-1:0]      rsp_count_in;
   logic                    req_fire;
   logic                    commit;
   logic                    full;
   logic                    found;
   cell_ctrl_type           ctrl;

   logic signed [KEY_W-1:0] cell_key [CAPACITY];
   logic                    cell_gt  [CAPACITY];
   logic [CAPACITY-1:0]     cell_hit;

   assign req_tready = (state_ff == FSM_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign found      = |cell_hit;

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff <= req_tdata[MODE_W-1:0];
         key_ff  <= req_tdata[MODE_W +: KEY_W];
      end
   end

   // Sequencer and result decode
   always_comb begin
      state_in      = state_ff;
      commit        = 1'b0;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      ctrl          = '0;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               commit   = 1'b1;
               state_in = FSM_IDLE;
               priority if (mode_ff[1]) begin
                  count_in      = '0;
                  rsp_status_in = ST_CLEARED;
               end else if (mode_ff == MODE_INSERT) begin
                  if (full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     ctrl.insert_en = 1'b1;
                     count_in       = count_ff + CNT_W'(1);
                     rsp_status_in  = ST_INSERTED;
                  end
               end else begin
                  if (found) begin
                     ctrl.remove_en = 1'b1;
                     count_in       = count_ff - CNT_W'(1);
                     rsp_status_in  = ST_DELETED;
                  end else begin
                     rsp_status_in = ST_NOT_FOUND;
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_count_in = ENTRY_W'(count_in);
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold response payload
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   // Row of cells wired to their neighbors; the first cell's left input is the probe key
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_W-1:0] left_key;
      logic                    left_gt;
      logic signed [KEY_W-1:0] right_key;

      if (i == 0) begin : g_first
         assign left_key = key_ff;
         assign left_gt  = 1'b0;
      end else begin : g_inner
         assign left_key = cell_key[i-1];
         assign left_gt  = cell_gt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_key = cell_key[i];
      end else begin : g_body
         assign right_key = cell_key[i+1];
      end

      skt_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .count     (count_ff),
         .probe_key (key_ff),
         .ctrl      (ctrl),
         .left_key  (left_key),
         .left_gt   (left_gt),
         .right_key (right_key),
         .key_q     (cell_key[i]),
         .gt        (cell_gt[i]),
         .hit       (cell_hit[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - STATUS_W - ENTRY_W){1'b0}}, rsp_count_ff, rsp_status_ff};

endmodule

// ===== rtl/skt_checker.sv =====
// Port-level checks for the sorted key table, bound to the top level.
`timescale 1ns / 1ps
`include "sorted_key_table_unit_defines.svh"

module skt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [skt_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import skt_pkg::*;

   logic       req_beat;
   logic [2:0] st;
   logic [6:0] cnt;
   logic       pad_zero;

   assign req_beat = req_tvalid && req_tready;
   assign st       = rsp_tdata[2:0];
   assign cnt      = rsp_tdata[9:3];
   assign pad_zero = (rsp_tdata[RSP_DATA_W-1:10] == '0);

   // Stalled response beat holds
   `SKT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // A taken request keeps the block busy for the next cycle
   `SKT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_beat, !req_tready)

   // Status codes stay in range and padding stays zero
   `SKT_ASSERT_IMPLY(a_status_range, clock, reset, rsp_tvalid, (st < 3'd5) && pad_zero)

   // A clear leaves an empty table
   `SKT_ASSERT_IMPLY(a_clear_empty, clock, reset, rsp_tvalid && (st == ST_CLEARED), cnt == 7'd0)

endmodule

bind sorted_key_table_unit skt_checker u_skt_checker (.*);

// ===== sim/tb_sorted_key_table_unit.sv =====
// Self-checking stream testbench for the sorted key table unit, with its own table model.
`timescale 1ns / 1ps

module tb_sorted_key_table_unit;
   import skt_pkg::*;

   localparam int TABLE_DEPTH   = 64;
   localparam int LONG_HOLD     = 200;
   localparam int MAX_IDLE      = 17;
   localparam int SETTLE_CYCLES = 30;
   localparam int ITEM_TARGET   = 1050;
   localparam int CALM_EVERY    = 50;

   // Both clear codes: the high mode bit selects clear
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR_ALT = 2'd3;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   typedef enum int {
      PH_GROW,
      PH_SHRINK,
      PH_MIXED,
      PH_NOISE
   } phase_kind_type;

   typedef struct {
      logic [MODE_W-1:0]       mode;
      logic signed [KEY_W-1:0] key;
      int unsigned             gap;
      bit                      drain;
      bit                      hold_rsp;
   } table_request_type;

   typedef struct packed {
      status_type         status;
      logic [ENTRY_W-1:0] entry_count;
   } table_reply_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // mode[1:0], key[33:2], zero pad
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // status[2:0], entry_count[9:3], pad

   // Handshake flags sampled at the rising edge
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;

   // Stimulus and expectations
   table_request_type       pending_requests[$];
   table_reply_type         expected_replies[$];
   logic signed [KEY_W-1:0] held_keys[$];
   int                      error_count  = 0;
   int                      item_total   = 0;
   bit                      sender_quiet = 1'b0;

   // Sender state
   table_request_type cur_request;
   bit                loaded    = 1'b0;
   bit                showing   = 1'b0;
   int unsigned       gap_left  = 0;
   int                hold_token = 0;

   // Receiver state
   int          hold_seen    = 0;
   int unsigned hold_left    = 0;
   int unsigned rsp_wait     = 0;
   int          replies_seen = 0;
   bit          rsp_quiet    = 1'b0;

   sorted_key_table_unit #(
      .CAPACITY (TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Hold reset at start, release on a falling edge
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   function automatic int unsigned draw_gap(bit quiet);
      if (quiet || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, MAX_IDLE);
   endfunction

   task automatic push_request(input logic [MODE_W-1:0] mode,
                               input logic signed [KEY_W-1:0] key,
                               input bit drain, input bit hold_rsp);
      table_request_type item;
      item.mode     = mode;
      item.key      = key;
      item.gap      = draw_gap(sender_quiet);
      item.drain    = drain;
      item.hold_rsp = hold_rsp;
      pending_requests.push_back(item);
      item_total++;
   endtask

   // Apply one operation to the ordered table and return the reply it yields
   function automatic table_reply_type apply_request(input logic [MODE_W-1:0] mode,
                                                     input logic signed [KEY_W-1:0] key);
      table_reply_type reply;
      int              slot;
      slot = 0;
      if (mode[1]) begin
         held_keys.delete();
         reply.status = ST_CLEARED;
      end else if (mode == MODE_INSERT) begin
         if (held_keys.size() >= TABLE_DEPTH) begin
            reply.status = ST_FULL;
         end else begin
            // place after every equal key
            while (slot < held_keys.size() && held_keys[slot] <= key) slot++;
            held_keys.insert(slot, key);
            reply.status = ST_INSERTED;
         end
      end else begin
         while (slot < held_keys.size() && held_keys[slot] < key) slot++;
         if (slot < held_keys.size() && held_keys[slot] == key) begin
            held_keys.delete(slot);
            reply.status = ST_DELETED;
         end else begin
            reply.status = ST_NOT_FOUND;
         end
      end
      reply.entry_count = ENTRY_W'(held_keys.size());
      return reply;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ns: %s", $realtime, msg);
   endtask

   // Sender: present one beat at a time, honoring gaps and drain points
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_fire) showing = 1'b0;
         if (!showing) begin
            if (!loaded && pending_requests.size() != 0) begin
               cur_request = pending_requests.pop_front();
               gap_left    = cur_request.gap;
               loaded      = 1'b1;
            end
            if (loaded && !(cur_request.drain && expected_replies.size() != 0)) begin
               if (gap_left != 0) begin
                  gap_left--;
               end else begin
                  showing = 1'b1;
                  loaded  = 1'b0;
                  req_tdata <= {{(REQ_DATA_W - MODE_W - KEY_W){1'b0}},
                                cur_request.key, cur_request.mode};
                  if (cur_request.hold_rsp) hold_token <= hold_token + 1;
               end
            end
         end
         req_tvalid <= showing;
      end
   end

   // Receiver: random stalls per beat, calm stretches, and one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            replies_seen++;
            if (replies_seen % CALM_EVERY == 0) rsp_quiet = !rsp_quiet;
            rsp_wait = draw_gap(rsp_quiet);
         end
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: predict on each accepted request beat, check each response beat
   always @(posedge clock) begin
      table_reply_type     want;
      logic [STATUS_W-1:0] got_status;
      logic [ENTRY_W-1:0]  got_count;
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         rsp_fire <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready)
            expected_replies.push_back(apply_request(req_tdata[MODE_W-1:0],
                                                     req_tdata[MODE_W +: KEY_W]));
         if (rsp_tvalid && rsp_tready) begin
            got_status = rsp_tdata[STATUS_W-1:0];
            got_count  = rsp_tdata[STATUS_W +: ENTRY_W];
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("response beat with none expected: status %0d count %0d",
                                         got_status, got_count));
            end else begin
               want = expected_replies.pop_front();
               if (got_status != want.status)
                  report_mismatch($sformatf("status mismatch: got %0d, want %0d",
                                            got_status, want.status));
               if (got_count != want.entry_count)
                  report_mismatch($sformatf("entry_count mismatch: got %0d, want %0d",
                                            got_count, want.entry_count));
            end
         end
      end
   end

   // Stimulus, then wait for the last response
   initial begin
      logic signed [KEY_W-1:0] pool[8];
      logic signed [KEY_W-1:0] fill_keys[$];
      logic signed [KEY_W-1:0] key;
      logic [MODE_W-1:0]       mode;
      phase_kind_type          phase_kind;
      int                      phase_len;
      int                      roll;
      int                      ins_cut;
      int                      del_cut;

      // Directed: missing keys, extremes, duplicates, both clear codes
      push_request(MODE_DELETE, 32'sd5, 1'b0, 1'b0);
      push_request(MODE_INSERT, 32'sd0, 1'b0, 1'b0);
      push_request(MODE_INSERT, KEY_MIN, 1'b0, 1'b0);
      push_request(MODE_INSERT, KEY_MAX, 1'b0, 1'b0);
      push_request(MODE_INSERT, -32'sd1, 1'b0, 1'b0);
      push_request(MODE_INSERT, 32'sd1, 1'b0, 1'b0);
      push_request(MODE_INSERT, 32'sd0, 1'b0, 1'b0);
      push_request(MODE_DELETE, 32'sd0, 1'b0, 1'b0);
      push_request(MODE_DELETE, 32'sd0, 1'b0, 1'b0);
      push_request(MODE_DELETE, 32'sd0, 1'b0, 1'b0);
      push_request(MODE_DELETE, 32'sd7, 1'b0, 1'b0);
      push_request(MODE_DELETE, KEY_MIN, 1'b0, 1'b0);
      push_request(MODE_DELETE, KEY_MAX, 1'b0, 1'b0);
      push_request(MODE_INSERT, 32'sh5555_5555, 1'b0, 1'b0);
      push_request(MODE_INSERT, 32'shAAAA_AAAA, 1'b0, 1'b0);
      push_request(MODE_CLEAR_ALT, KEY_MAX, 1'b0, 1'b0);
      push_request(MODE_DELETE, -32'sd1, 1'b0, 1'b0);
      push_request(MODE_INSERT, 32'sd42, 1'b0, 1'b0);
      push_request(MODE_CLEAR, 32'sd0, 1'b0, 1'b0);

      // Fill past capacity back to back while the receiver holds off
      sender_quiet = 1'b1;
      push_request(MODE_CLEAR, 32'sd0, 1'b1, 1'b0);
      for (int n = 0; n < 70; n++) begin
         if ($urandom_range(0, 1) == 0) key = $urandom_range(0, 15) - 8;
         else key = $urandom;
         fill_keys.push_back(key);
         push_request(MODE_INSERT, key, 1'b0, n == 4);
      end
      sender_quiet = 1'b0;

      // Pause until the table has answered everything, then delete fill keys at random
      push_request(MODE_DELETE, fill_keys[0], 1'b1, 1'b0);
      for (int n = 0; n < 40; n++)
         push_request(MODE_DELETE, fill_keys[$urandom_range(0, fill_keys.size() - 1)],
                      1'b0, 1'b0);

      // Random phases over a small key pool so deletes and duplicates hit
      while (item_total < ITEM_TARGET) begin
         phase_kind   = phase_kind_type'($urandom_range(0, 3));
         phase_len    = $urandom_range(20, 80);
         sender_quiet = ($urandom_range(0, 3) == 0);
         for (int p = 0; p < 8; p++) begin
            case ($urandom_range(0, 2))
               0: pool[p] = $urandom;
               1: pool[p] = $urandom_range(0, 20) - 10;
               default: begin
                  case ($urandom_range(0, 3))
                     0:       pool[p] = KEY_MIN;
                     1:       pool[p] = KEY_MAX;
                     2:       pool[p] = 32'sd0;
                     default: pool[p] = -32'sd1;
                  endcase
               end
            endcase
         end
         case (phase_kind)
            PH_GROW: begin
               ins_cut = 80;
               del_cut = 99;
            end
            PH_SHRINK: begin
               ins_cut = 20;
               del_cut = 98;
            end
            PH_MIXED: begin
               ins_cut = 48;
               del_cut = 96;
            end
            default: begin
               ins_cut = 40;
               del_cut = 80;
            end
         endcase
         for (int n = 0; n < phase_len; n++) begin
            roll = $urandom_range(0, 99);
            if (phase_kind == PH_NOISE || $urandom_range(0, 6) == 0) key = $urandom;
            else key = pool[$urandom_range(0, 7)];
            if (roll < ins_cut) mode = MODE_INSERT;
            else if (roll < del_cut) mode = MODE_DELETE;
            else if (phase_kind == PH_NOISE && roll >= 90) mode = MODE_W'($urandom_range(0, 3));
            else if ($urandom_range(0, 1) == 0) mode = MODE_CLEAR;
            else mode = MODE_CLEAR_ALT;
            push_request(mode, key, n == 0 && $urandom_range(0, 3) == 0, 1'b0);
         end
      end

      while (pending_requests.size() != 0 || loaded || showing || expected_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sorted_key_table_unit.f =====
+incdir+rtl
rtl/skt_pkg.sv
rtl/skt_cell.sv
rtl/sorted_key_table_unit.sv
rtl/skt_checker.sv
sim/tb_sorted_key_table_unit.sv
